FILE: sv/ahdlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahdlc_pkg
// Shared constants, the item type and the crc-16 byte fold for the async
// hdlc frame encoder.
// ----------------------------------------------------------------------------
package ahdlc_pkg;

  localparam logic [15:0] CrcSeed  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h8408;
  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;

  // one accepted byte with the frame check sequence already worked out
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] fcs;
  } item_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FlagByte) || (b == EscByte);
  endfunction

endpackage
`default_nettype wire

FILE: sv/async_hdlc_frame_encoder_crc16.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// async_hdlc_frame_encoder_crc16
// Async hdlc framer: escapes payload bytes, appends the x.25 crc-16 and the
// closing flag.
// ----------------------------------------------------------------------------
// usage
//   input channel: one payload byte per transaction on data_byte_i, with
//   last_byte_i set on the final byte of a frame. output channel: one framed
//   byte per transaction on out_byte_o, end_of_frame_o set on the closing 0x7e.
//   the crc is folded at input acceptance; a holding stage then walks the
//   item's bytes out one per cycle, unless stalled, into the output register.
//   the first output byte passes the holding stage, then the output register.
//   throughput: one output byte per cycle while not stalled; an escaped byte
//   goes out as two bytes; a last byte adds crc low, crc high and the flag.
//   the next input is taken in the cycle the previous item's final byte
//   leaves the holding stage; plain bytes stream at one per cycle unstalled.
//   reset empties both stages and loads the crc seed 0xffff.
//   a stall on the output holds the output register and the holding stage;
//   stall_o then rises once the holding stage is occupied.
// ----------------------------------------------------------------------------
module async_hdlc_frame_encoder_crc16 (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       stall_o,
  input  wire  [7:0] data_byte_i,
  input  wire        last_byte_i,
  output logic       valid_o,
  input  wire        stall_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_frame_o
);

  logic [15:0]      crc_q;
  logic [15:0]      crc_next;
  logic             ready;
  logic             accept;
  ahdlc_pkg::item_t item;

  assign stall_o  = !ready;
  assign accept   = valid_i && ready;
  assign crc_next = ahdlc_pkg::crc_fold(crc_q, data_byte_i);

  always_comb begin
    item.data = data_byte_i;
    item.last = last_byte_i;
    item.fcs  = ~crc_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= ahdlc_pkg::CrcSeed;
    end else if (accept) begin
      crc_q <= last_byte_i ? ahdlc_pkg::CrcSeed : crc_next;
    end
  end

  ahdlc_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .item_i         (item),
    .ready_o        (ready),
    .out_byte_o     (out_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .valid_o        (valid_o),
    .stall_i        (stall_i)
  );

endmodule
`default_nettype wire

FILE: sv/ahdlc_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahdlc_emitter
// Holds an item, walks it out one byte per cycle unless stalled, to an output
// register: payload, on a last byte crc low, high (escaped as needed), flag.
// ----------------------------------------------------------------------------
module ahdlc_emitter (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   load_i,
  input  wire ahdlc_pkg::item_t item_i,
  output logic                  ready_o,
  output logic [7:0]            out_byte_o,
  output logic                  end_of_frame_o,
  output logic                  valid_o,
  input  wire                   stall_i
);

  typedef enum logic [2:0] {
    PH_DATA,
    PH_DATA_X,
    PH_LO,
    PH_LO_X,
    PH_HI,
    PH_HI_X,
    PH_FLAG
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             hold_valid_q;
  ahdlc_pkg::item_t item_q;
  logic [7:0]       out_byte_q;
  logic             out_eof_q;
  logic             out_valid_q;

  logic       out_free;
  logic       emit;
  logic       final_byte;
  logic [7:0] emit_byte;
  logic       emit_eof;
  logic [7:0] fcs_lo;
  logic [7:0] fcs_hi;

  assign fcs_lo   = item_q.fcs[7:0];
  assign fcs_hi   = item_q.fcs[15:8];
  assign out_free = !out_valid_q || !stall_i;
  assign emit     = hold_valid_q && out_free;

  always_comb begin
    emit_byte  = item_q.data;
    emit_eof   = 1'b0;
    final_byte = 1'b0;
    phase_d    = phase_q;
    case (phase_q)
      PH_DATA: begin
        if (ahdlc_pkg::needs_escape(item_q.data)) begin
          emit_byte = ahdlc_pkg::EscByte;
          phase_d   = PH_DATA_X;
        end else begin
          emit_byte  = item_q.data;
          final_byte = !item_q.last;
          phase_d    = PH_LO;
        end
      end
      PH_DATA_X: begin
        emit_byte  = item_q.data ^ ahdlc_pkg::EscXor;
        final_byte = !item_q.last;
        phase_d    = PH_LO;
      end
      PH_LO: begin
        if (ahdlc_pkg::needs_escape(fcs_lo)) begin
          emit_byte = ahdlc_pkg::EscByte;
          phase_d   = PH_LO_X;
        end else begin
          emit_byte = fcs_lo;
          phase_d   = PH_HI;
        end
      end
      PH_LO_X: begin
        emit_byte = fcs_lo ^ ahdlc_pkg::EscXor;
        phase_d   = PH_HI;
      end
      PH_HI: begin
        if (ahdlc_pkg::needs_escape(fcs_hi)) begin
          emit_byte = ahdlc_pkg::EscByte;
          phase_d   = PH_HI_X;
        end else begin
          emit_byte = fcs_hi;
          phase_d   = PH_FLAG;
        end
      end
      PH_HI_X: begin
        emit_byte = fcs_hi ^ ahdlc_pkg::EscXor;
        phase_d   = PH_FLAG;
      end
      PH_FLAG: begin
        emit_byte  = ahdlc_pkg::FlagByte;
        emit_eof   = 1'b1;
        final_byte = 1'b1;
        phase_d    = PH_DATA;
      end
      default: begin
        phase_d = PH_DATA;
      end
    endcase
  end

  // the holder frees up in the same cycle its last byte moves out
  assign ready_o = !hold_valid_q || (emit && final_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DATA;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        out_byte_q <= emit_byte;
        out_eof_q  <= emit_eof;
      end
      if (load_i) begin
        item_q       <= item_i;
        hold_valid_q <= 1'b1;
        phase_q      <= PH_DATA;
      end else if (emit) begin
        if (final_byte) begin
          hold_valid_q <= 1'b0;
          phase_q      <= PH_DATA;
        end else begin
          phase_q <= phase_d;
        end
      end
    end
  end

  assign out_byte_o     = out_byte_q;
  assign end_of_frame_o = out_eof_q;
  assign valid_o        = out_valid_q;

endmodule
`default_nettype wire

FILE: tb/hdlc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_frame_checker
// Watches both channels of the async hdlc framer. Every accepted payload byte
// is folded into its own running crc-16 and turned into the framed bytes the
// line should carry; every accepted output byte is compared in order.
// ----------------------------------------------------------------------------
module hdlc_frame_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  wire  [7:0] in_data_i,
  input  wire        in_last_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  wire  [7:0] out_byte_i,
  input  wire        out_eof_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] octet;
    logic       eof;
  } line_byte_t;

  line_byte_t  line_q[$];
  line_byte_t  want;
  logic [15:0] frame_crc;
  logic [15:0] fcs;
  int          fail_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = line_q.size();

  // bit-serial form of the reflected crc: feedback is crc lsb xor data bit
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ ahdlc_pkg::CrcPoly;
      end
    end
    return crc;
  endfunction

  task automatic queue_escaped(input logic [7:0] b);
    if (b == ahdlc_pkg::FlagByte || b == ahdlc_pkg::EscByte) begin
      line_q.push_back('{octet: ahdlc_pkg::EscByte, eof: 1'b0});
      line_q.push_back('{octet: b ^ ahdlc_pkg::EscXor, eof: 1'b0});
    end else begin
      line_q.push_back('{octet: b, eof: 1'b0});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_crc = ahdlc_pkg::CrcSeed;
      fail_cnt  = 0;
      line_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        frame_crc = crc16_add_byte(frame_crc, in_data_i);
        queue_escaped(in_data_i);
        if (in_last_i) begin
          fcs = ~frame_crc;
          queue_escaped(fcs[7:0]);
          queue_escaped(fcs[15:8]);
          line_q.push_back('{octet: ahdlc_pkg::FlagByte, eof: 1'b1});
          frame_crc = ahdlc_pkg::CrcSeed;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (line_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected output transaction, expected none, got %02h eof %0b",
                   $time, out_byte_i, out_eof_i);
        end else begin
          want = line_q.pop_front();
          if (out_byte_i !== want.octet) begin
            fail_cnt++;
            $display("%0t: out_byte expected %02h, got %02h", $time, want.octet, out_byte_i);
          end
          if (out_eof_i !== want.eof) begin
            fail_cnt++;
            $display("%0t: end_of_frame expected %0b, got %0b", $time, want.eof, out_eof_i);
          end
        end
      end
    end
  end

endmodule

FILE: tb/async_hdlc_frame_encoder_crc16_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_hdlc_frame_encoder_crc16_tb
// Drives payload frames into the hdlc framer under three idle patterns:
// directed frames for escaping and crc corner cases, then random frames.
// The checker beside the block predicts and compares the framed output.
// ----------------------------------------------------------------------------
module async_hdlc_frame_encoder_crc16_tb;

  localparam int StallLimit = 2000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       valid_i     = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       stall_i     = 1'b0;
  logic       stall_o;
  logic       valid_o;
  logic [7:0] out_byte_o;
  logic       end_of_frame_o;

  int fail_count;
  int pending_bytes;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  async_hdlc_frame_encoder_crc16 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .out_byte_o     (out_byte_o),
    .end_of_frame_o (end_of_frame_o)
  );

  hdlc_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_stall_i   (stall_o),
    .in_data_i    (data_byte_i),
    .in_last_i    (last_byte_i),
    .out_valid_i  (valid_o),
    .out_stall_i  (stall_i),
    .out_byte_i   (out_byte_o),
    .out_eof_i    (end_of_frame_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes)
  );

  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // ends the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic lb);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i     <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lb;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_random_frame();
    int         len;
    logic [7:0] b;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(5))
        0: b = $urandom_range(1) ? ahdlc_pkg::FlagByte : ahdlc_pkg::EscByte;
        1: b = $urandom_range(1) ? (ahdlc_pkg::FlagByte ^ ahdlc_pkg::EscXor)
                                 : (ahdlc_pkg::EscByte ^ ahdlc_pkg::EscXor);
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, k == len - 1);
    end
  endtask

  // sender holds off until the line has delivered everything
  task automatic drain_line();
    valid_i <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct, input int count);
    int target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = items_sent + count;
    while (items_sent < target) send_random_frame();
    drain_line();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 32;
    rx_idle_pct = 77;
    // single-byte frames, data extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // crc low byte comes out as a flag and needs escaping
    send_byte(8'hF1, 1'b1);
    // crc high byte needs escaping, flag then escape value
    send_byte(8'h2A, 1'b1);
    send_byte(8'h19, 1'b1);
    // escaped byte as the last of its frame
    send_byte(ahdlc_pkg::FlagByte, 1'b1);
    // escape characters and their look-alikes inside a frame
    send_byte(ahdlc_pkg::FlagByte, 1'b0);
    send_byte(ahdlc_pkg::EscByte, 1'b0);
    send_byte(ahdlc_pkg::FlagByte ^ ahdlc_pkg::EscXor, 1'b0);
    send_byte(ahdlc_pkg::EscByte ^ ahdlc_pkg::EscXor, 1'b0);
    send_byte(ahdlc_pkg::EscXor, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_line();

    random_phase(32, 77, 150);
    random_phase(77, 32, 160);
    random_phase(0, 0, 150);

    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ahdlc_pkg.sv
sv/ahdlc_emitter.sv
sv/async_hdlc_frame_encoder_crc16.sv
tb/hdlc_frame_checker.sv
tb/async_hdlc_frame_encoder_crc16_tb.sv
